// ----- hw/rtl/rpn_pkg.sv -----
// Shared types, codes and arithmetic helpers for the RPN stack evaluator.
`default_nettype none
package rpn_pkg;

  localparam int unsigned StackDepth = 128;

  typedef enum logic [3:0] {
    FN_PUSH  = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_MOD   = 4'd5,
    FN_SHOW  = 4'd6,
    FN_DUP   = 4'd7,
    FN_SWAP  = 4'd8,
    FN_CLEAR = 4'd9,
    FN_POP   = 4'd10
  } func_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_EMPTY   = 3'd1,
    ERR_FULL    = 3'd2,
    ERR_DIV0    = 3'd3,
    ERR_MOD0    = 3'd4,
    ERR_SWAP    = 3'd5,
    ERR_UNKNOWN = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SHOW = 2'd1,
    KIND_POP  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_B,
    ST_WAIT_B,
    ST_RD_A,
    ST_WAIT_A,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_FIX,
    ST_WRITE,
    ST_SWAP_W,
    ST_OUT
  } state_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_B,
    OP_LOAD_A,
    OP_MUL,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_FIX
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rpn_datapath.sv -----
// Datapath: operand registers, multiplier, iterative divider and result select.
`default_nettype none
module rpn_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rpn_pkg::dp_cmd_t     cmd,
  input  wire rpn_pkg::func_t       func,
  input  wire logic [31:0]          rd_data,
  input  wire logic                 b_valid,
  input  wire logic                 a_valid,
  output rpn_pkg::dp_sts_t          sts,
  output logic [31:0]               result,
  output logic                      b_zero
);

  logic signed [31:0] a_reg;
  logic signed [31:0] b_reg;
  logic signed [63:0] prod;
  logic [63:0]        rem;
  logic [47:0]        quot;
  logic [31:0]        dvsr;
  logic [5:0]         cnt;
  logic               neg;
  logic [31:0]        qres;
  logic [47:0]        num_mag;
  logic [15:0]        ia_mag;
  logic [15:0]        ib_mag;
  logic [48:0]        trial;
  logic               is_mod;

  always_comb begin
    // integer parts truncated toward zero
    ia_mag = a_reg[31] ? 16'((-33'(a_reg)) >>> 16) : a_reg[31:16];
    ib_mag = b_reg[31] ? 16'((-33'(b_reg)) >>> 16) : b_reg[31:16];
  end

  assign is_mod = (func == rpn_pkg::FN_MOD);
  assign b_zero = is_mod ? (ib_mag == 16'd0) : (b_reg == 32'sd0);

  always_comb begin
    logic [31:0] am;
    am = a_reg[31] ? 32'(-33'(a_reg)) : 32'(a_reg);
    num_mag = is_mod ? 48'(ia_mag) : {am, 16'd0};
  end

  assign trial = {rem[47:0], quot[47]} - {17'd0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else begin
      case (cmd.op)
        rpn_pkg::OP_LOAD_B: b_reg <= b_valid ? rd_data : 32'd0;
        rpn_pkg::OP_LOAD_A: a_reg <= a_valid ? rd_data : 32'd0;
        rpn_pkg::OP_MUL: prod <= a_reg * b_reg;
        rpn_pkg::OP_DIV_START: begin
          quot <= num_mag;
          rem  <= 64'd0;
          dvsr <= is_mod ? 32'(ib_mag) : (b_reg[31] ? 32'(-33'(b_reg)) : 32'(b_reg));
          neg  <= is_mod ? a_reg[31] : (a_reg[31] ^ b_reg[31]);
          cnt  <= 6'd48;
        end
        rpn_pkg::OP_DIV_STEP: begin
          if (!trial[48]) begin
            rem  <= 64'(trial[47:0]);
            quot <= {quot[46:0], 1'b1};
          end else begin
            rem  <= {rem[62:0], quot[47]};
            quot <= {quot[46:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
        end
        rpn_pkg::OP_DIV_FIX: begin
          if (is_mod) begin
            qres <= neg ? 32'({-17'(rem[15:0]), 16'd0}) : {rem[15:0], 16'd0};
          end else begin
            qres <= rpn_pkg::sat32(neg ? -66'(quot) : 66'(quot));
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.div_done = (cnt == 6'd1);

  always_comb begin
    logic signed [65:0] s;
    s = 66'sd0;
    case (func)
      rpn_pkg::FN_ADD: s = 66'(a_reg) + 66'(b_reg);
      rpn_pkg::FN_SUB: s = 66'(a_reg) - 66'(b_reg);
      rpn_pkg::FN_MUL: s = 66'(prod >>> 16);
      default: s = 66'sd0;
    endcase
    if (func == rpn_pkg::FN_DIV || func == rpn_pkg::FN_MOD) result = qres;
    else result = rpn_pkg::sat32(s);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rpn_ctrl.sv -----
// Controller state machine: sequences stack reads, datapath work and writes.
`default_nettype none
module rpn_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire rpn_pkg::func_t in_func,
  input  wire rpn_pkg::func_t func,
  input  wire logic           out_free,
  input  wire rpn_pkg::dp_sts_t sts,
  output rpn_pkg::state_t     state,
  output rpn_pkg::dp_cmd_t    cmd
);

  rpn_pkg::state_t state_next;
  logic binop;

  // decode the incoming request, the registered copy is not loaded yet
  assign binop = (in_func == rpn_pkg::FN_ADD) || (in_func == rpn_pkg::FN_SUB) ||
                 (in_func == rpn_pkg::FN_MUL) || (in_func == rpn_pkg::FN_DIV) ||
                 (in_func == rpn_pkg::FN_MOD);

  always_ff @(posedge clk) begin
    if (rst) state <= rpn_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::ST_IDLE:    if (in_fire) state_next = binop ? rpn_pkg::ST_RD_B : rpn_pkg::ST_WRITE;
      rpn_pkg::ST_RD_B:    state_next = rpn_pkg::ST_WAIT_B;
      rpn_pkg::ST_WAIT_B:  state_next = rpn_pkg::ST_RD_A;
      rpn_pkg::ST_RD_A:    state_next = rpn_pkg::ST_WAIT_A;
      rpn_pkg::ST_WAIT_A: begin
        if (func == rpn_pkg::FN_MUL) state_next = rpn_pkg::ST_MUL;
        else if (func == rpn_pkg::FN_DIV || func == rpn_pkg::FN_MOD)
          state_next = rpn_pkg::ST_DIV_START;
        else state_next = rpn_pkg::ST_WRITE;
      end
      rpn_pkg::ST_MUL:     state_next = rpn_pkg::ST_WRITE;
      rpn_pkg::ST_DIV_START: state_next = rpn_pkg::ST_DIV;
      rpn_pkg::ST_DIV:     if (sts.div_done) state_next = rpn_pkg::ST_DIV_FIX;
      rpn_pkg::ST_DIV_FIX: state_next = rpn_pkg::ST_WRITE;
      rpn_pkg::ST_WRITE:   state_next = (func == rpn_pkg::FN_SWAP) ? rpn_pkg::ST_SWAP_W
                                                                  : rpn_pkg::ST_OUT;
      rpn_pkg::ST_SWAP_W:  state_next = rpn_pkg::ST_OUT;
      rpn_pkg::ST_OUT:     if (out_free) state_next = rpn_pkg::ST_IDLE;
      default:             state_next = rpn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = rpn_pkg::OP_NONE;
    case (state)
      rpn_pkg::ST_WAIT_B: cmd.op = rpn_pkg::OP_LOAD_B;
      rpn_pkg::ST_WAIT_A: begin
        cmd.op = rpn_pkg::OP_LOAD_A;
      end
      rpn_pkg::ST_MUL:    cmd.op = rpn_pkg::OP_MUL;
      rpn_pkg::ST_DIV_START: cmd.op = rpn_pkg::OP_DIV_START;
      rpn_pkg::ST_DIV:    cmd.op = rpn_pkg::OP_DIV_STEP;
      rpn_pkg::ST_DIV_FIX: cmd.op = rpn_pkg::OP_DIV_FIX;
      default: cmd.op = rpn_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rpn_stack_evaluator.sv -----
// Top level: RPN evaluator on a Q16.16 stack held in a memory with one write port and two registered reads.
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_axis_tvalid/tready  | tdata: func[3:0], operand[35:4]
//  m_axis  | out | m_axis_tvalid/tready  | tdata: kind[1:0], value[33:2], error[36:34]
//
// One token at a time: ready stays low from acceptance until the result is registered;
// div and mod run through the 48-step radix-2 divider. The result turns valid in the
// cycle ready returns.
// Reset clears the count; memory is not cleared.
// A held output stalls the controller in its output state until taken.
`default_nettype none
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::StackDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // func[3:0], operand[35:4], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // kind[1:0], value[33:2], error[36:34], zero pad
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::state_t  state;
  rpn_pkg::dp_cmd_t cmd;
  rpn_pkg::dp_sts_t sts;
  rpn_pkg::func_t   func;
  logic [31:0]      operand;
  logic [CW-1:0]    count;
  logic [31:0]      mem [STACK_DEPTH];
  logic [31:0]      top_reg;
  logic [31:0]      result;
  logic             b_valid;
  logic             a_valid;
  logic             b_zero;
  logic             in_fire;
  logic [2:0]       err;
  logic [1:0]       kind;
  logic [31:0]      value;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      wr_data;
  logic [31:0]      top_mem;
  logic [31:0]      sec_mem;
  logic             out_free;

  assign s_axis_tready = (state == rpn_pkg::ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func    <= rpn_pkg::func_t'(s_axis_tdata[3:0]);
      operand <= s_axis_tdata[35:4];
    end
  end

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_func(rpn_pkg::func_t'(s_axis_tdata[3:0])), .func(func), .out_free(out_free),
    .sts(sts), .state(state), .cmd(cmd)
  );

  rpn_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .func(func), .rd_data(top_mem),
    .b_valid(b_valid), .a_valid(a_valid), .sts(sts), .result(result), .b_zero(b_zero)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered reads of the top two entries; the top one also feeds the operand loads
  always_ff @(posedge clk) begin
    top_mem <= mem[AW'(count - CW'(1))];
    sec_mem <= mem[AW'(count - CW'(2))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      b_valid <= 1'b0;
      a_valid <= 1'b0;
      err     <= rpn_pkg::ERR_NONE;
      kind    <= rpn_pkg::KIND_NONE;
      value   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // hold the result in the output register until taken
      if (state == rpn_pkg::ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {3'd0, err, value, kind};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        rpn_pkg::ST_IDLE: if (in_fire) begin
          err   <= rpn_pkg::ERR_NONE;
          kind  <= rpn_pkg::KIND_NONE;
          value <= '0;
        end
        rpn_pkg::ST_RD_B: begin
          b_valid <= (count != '0);
          if (count != '0) count <= count - CW'(1);
          else err <= rpn_pkg::ERR_EMPTY;
        end
        rpn_pkg::ST_WAIT_B: ;
        rpn_pkg::ST_RD_A: begin
          if (b_zero && (func == rpn_pkg::FN_DIV || func == rpn_pkg::FN_MOD)) begin
            a_valid <= 1'b0;
            if (err == rpn_pkg::ERR_NONE)
              err <= (func == rpn_pkg::FN_DIV) ? rpn_pkg::ERR_DIV0 : rpn_pkg::ERR_MOD0;
          end else begin
            a_valid <= (count != '0);
            if (count != '0) count <= count - CW'(1);
            else err <= rpn_pkg::ERR_EMPTY;
          end
        end
        rpn_pkg::ST_WRITE: begin
          case (func)
            rpn_pkg::FN_PUSH, rpn_pkg::FN_ADD, rpn_pkg::FN_SUB, rpn_pkg::FN_MUL: begin
              if (count < CW'(STACK_DEPTH)) count <= count + CW'(1);
              else if (err == rpn_pkg::ERR_NONE) err <= rpn_pkg::ERR_FULL;
            end
            rpn_pkg::FN_DIV, rpn_pkg::FN_MOD: begin
              // drop the zero divisor, push nothing
              if (!b_zero) begin
                if (count < CW'(STACK_DEPTH)) count <= count + CW'(1);
                else if (err == rpn_pkg::ERR_NONE) err <= rpn_pkg::ERR_FULL;
              end
            end
            rpn_pkg::FN_SHOW: begin
              if (count != '0) begin
                kind <= rpn_pkg::KIND_SHOW;
                value <= top_mem;
              end else err <= rpn_pkg::ERR_EMPTY;
            end
            rpn_pkg::FN_DUP: begin
              if (count == '0) err <= rpn_pkg::ERR_EMPTY;
              else if (count < CW'(STACK_DEPTH)) count <= count + CW'(1);
              else err <= rpn_pkg::ERR_FULL;
            end
            rpn_pkg::FN_SWAP: if (count < CW'(2)) err <= rpn_pkg::ERR_SWAP;
            rpn_pkg::FN_CLEAR: count <= '0;
            rpn_pkg::FN_POP: begin
              kind <= rpn_pkg::KIND_POP;
              if (count != '0) begin
                value <= top_mem;
                count <= count - CW'(1);
              end else err <= rpn_pkg::ERR_EMPTY;
            end
            default: err <= rpn_pkg::ERR_UNKNOWN;
          endcase
        end
        default: ;
      endcase
    end
  end

  // write port: push operand or result, dup, or the two swap writes
  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(count);
    wr_data = result;
    if (state == rpn_pkg::ST_WRITE) begin
      case (func)
        rpn_pkg::FN_PUSH: begin
          wr_en = (count < CW'(STACK_DEPTH));
          wr_data = operand;
        end
        rpn_pkg::FN_ADD, rpn_pkg::FN_SUB, rpn_pkg::FN_MUL:
          wr_en = (count < CW'(STACK_DEPTH));
        rpn_pkg::FN_DIV, rpn_pkg::FN_MOD: begin
          // a zero divisor leaves a in place, already in memory
          wr_en = !b_zero && (count < CW'(STACK_DEPTH));
        end
        rpn_pkg::FN_DUP: begin
          wr_en = (count != '0) && (count < CW'(STACK_DEPTH));
          wr_data = top_mem;
        end
        rpn_pkg::FN_SWAP: begin
          wr_en = (count >= CW'(2));
          wr_addr = AW'(count - CW'(1));
          wr_data = sec_mem;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (state == rpn_pkg::ST_SWAP_W) begin
      wr_en = (count >= CW'(2));
      wr_addr = AW'(count - CW'(2));
      wr_data = top_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rpn_pkg::ST_WRITE) top_reg <= top_mem;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while waiting");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == rpn_pkg::ST_OUT))
    else $error("result shown outside output state");
`endif

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the RPN stack evaluator: directed token table, stack fill, then random token streams.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = int'(rpn_pkg::StackDepth);
  localparam int NumRandom = 1095;
  localparam longint CycleLimit = 2_000_000;
  localparam logic [3:0] FnUnknown = 4'd11;
  localparam logic [3:0] FnUnknownMax = 4'd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  error;
  } answer_t;

  typedef struct {
    logic [3:0]  func;
    logic [31:0] operand;
    bit          typed;
    answer_t     ans;
  } token_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  rpn_stack_evaluator DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [31:0] stk [Depth];
  int          depth_used;
  logic [2:0]  first_err;
  answer_t     answers_due[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  longint      cycles = 0;

  function automatic void note_err(logic [2:0] e);
    if (first_err == rpn_pkg::ERR_NONE) first_err = e;
  endfunction

  function automatic void push_word(logic [31:0] v);
    if (depth_used < Depth) begin
      stk[depth_used] = v;
      depth_used++;
    end else begin
      note_err(rpn_pkg::ERR_FULL);
    end
  endfunction

  function automatic logic signed [31:0] pop_word();
    if (depth_used > 0) begin
      depth_used--;
      return stk[depth_used];
    end
    note_err(rpn_pkg::ERR_EMPTY);
    return '0;
  endfunction

  function automatic logic [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint int_part(logic signed [31:0] x);
    longint w;
    w = x;
    return (w >= 0) ? (w >>> 16) : -((-w) >>> 16);
  endfunction

  function automatic answer_t evaluate_token(logic [3:0] func, logic [31:0] operand);
    answer_t r;
    logic signed [31:0] a, b;
    longint p, ia, ib;
    logic [31:0] t;
    r = '0;
    first_err = rpn_pkg::ERR_NONE;
    case (func)
      rpn_pkg::FN_PUSH: push_word(operand);
      rpn_pkg::FN_ADD, rpn_pkg::FN_SUB, rpn_pkg::FN_MUL: begin
        b = pop_word();
        a = pop_word();
        if (func == rpn_pkg::FN_ADD) p = longint'(a) + longint'(b);
        else if (func == rpn_pkg::FN_SUB) p = longint'(a) - longint'(b);
        else p = (longint'(a) * longint'(b)) >>> 16;
        push_word(clamp(p));
      end
      rpn_pkg::FN_DIV: begin
        b = pop_word();
        if (b != 0) begin
          a = pop_word();
          push_word(clamp((longint'(a) * 65536) / longint'(b)));
        end else begin
          note_err(rpn_pkg::ERR_DIV0);
        end
      end
      rpn_pkg::FN_MOD: begin
        b = pop_word();
        ib = int_part(b);
        if (ib != 0) begin
          a = pop_word();
          ia = int_part(a);
          push_word(clamp((ia % ib) * 65536));
        end else begin
          note_err(rpn_pkg::ERR_MOD0);
        end
      end
      rpn_pkg::FN_SHOW: begin
        if (depth_used > 0) begin
          r.kind = rpn_pkg::KIND_SHOW;
          r.value = stk[depth_used-1];
        end else begin
          note_err(rpn_pkg::ERR_EMPTY);
        end
      end
      rpn_pkg::FN_DUP: begin
        if (depth_used > 0) push_word(stk[depth_used-1]);
        else note_err(rpn_pkg::ERR_EMPTY);
      end
      rpn_pkg::FN_SWAP: begin
        if (depth_used > 1) begin
          t = stk[depth_used-1];
          stk[depth_used-1] = stk[depth_used-2];
          stk[depth_used-2] = t;
        end else begin
          note_err(rpn_pkg::ERR_SWAP);
        end
      end
      rpn_pkg::FN_CLEAR: depth_used = 0;
      rpn_pkg::FN_POP: begin
        r.kind = rpn_pkg::KIND_POP;
        r.value = pop_word();
      end
      default: note_err(rpn_pkg::ERR_UNKNOWN);
    endcase
    r.error = first_err;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3);
      3: return $signed($urandom_range(0, 20 << 16)) - (32'sd10 << 16);
      4: return $urandom_range(0, 9) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_token(logic [3:0] func, logic [31:0] operand);
    answer_t predicted;
    while (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, operand, func};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = evaluate_token(func, operand);
    answers_due.push_back(predicted);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tdata[1:0];
      got.value = m_axis_tdata[33:2];
      got.error = m_axis_tdata[36:34];
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d value %h/%h error %0d/%0d",
                     want.kind, got.kind, want.value, got.value, want.error, got.error);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 9);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    token_row_t rows[$];
    int len, sel;
    depth_used = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    rows = '{
      '{rpn_pkg::FN_SHOW, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_EMPTY}},
      '{rpn_pkg::FN_POP, 32'd0, 1,
        '{rpn_pkg::KIND_POP, 32'd0, rpn_pkg::ERR_EMPTY}},
      '{rpn_pkg::FN_DUP, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_EMPTY}},
      '{rpn_pkg::FN_SWAP, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_SWAP}},
      '{rpn_pkg::FN_ADD, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_EMPTY}},
      '{FnUnknown, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_UNKNOWN}},
      '{FnUnknownMax, 32'hFFFF_FFFF, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_UNKNOWN}},
      '{rpn_pkg::FN_PUSH, 32'h7FFF_FFFF, 0, '0},
      '{rpn_pkg::FN_DUP, 32'd0, 0, '0},
      '{rpn_pkg::FN_ADD, 32'd0, 0, '0},
      '{rpn_pkg::FN_PUSH, 32'h8000_0000, 0, '0},
      '{rpn_pkg::FN_MUL, 32'd0, 0, '0},
      '{rpn_pkg::FN_PUSH, 32'd0, 0, '0},
      '{rpn_pkg::FN_DIV, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_DIV0}},
      '{rpn_pkg::FN_PUSH, 32'h0000_8000, 0, '0},
      '{rpn_pkg::FN_MOD, 32'd0, 1,
        '{rpn_pkg::KIND_NONE, 32'd0, rpn_pkg::ERR_MOD0}},
      '{rpn_pkg::FN_PUSH, 32'hFFF9_0000, 0, '0},
      '{rpn_pkg::FN_PUSH, 32'h0002_0000, 0, '0},
      '{rpn_pkg::FN_SWAP, 32'd0, 0, '0},
      '{rpn_pkg::FN_MOD, 32'd0, 0, '0},
      '{rpn_pkg::FN_PUSH, 32'h0003_0000, 0, '0},
      '{rpn_pkg::FN_SUB, 32'd0, 0, '0},
      '{rpn_pkg::FN_SHOW, 32'd0, 0, '0},
      '{rpn_pkg::FN_POP, 32'd0, 0, '0},
      '{rpn_pkg::FN_CLEAR, 32'd0, 0, '0}
    };
    foreach (rows[i]) begin
      send_token(rows[i].func, rows[i].operand);
      if (rows[i].typed) answers_due[$] = rows[i].ans;
    end
    // fill to the limit, push past it once, then dup past it
    for (int i = 0; i <= Depth; i++) send_token(rpn_pkg::FN_PUSH, $urandom);
    send_token(rpn_pkg::FN_DUP, 32'd0);
    send_token(rpn_pkg::FN_CLEAR, 32'd0);
    // random expression streams, mostly well formed
    for (int i = 0; i < NumRandom; i++) begin
      if (i > NumRandom - 100) calm = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        send_token(rpn_pkg::FN_PUSH, rand_value());
      end else if (sel < 8) begin
        if (depth_used < 2) send_token(rpn_pkg::FN_PUSH, rand_value());
        else send_token(4'($urandom_range(rpn_pkg::FN_ADD, rpn_pkg::FN_MOD)), 32'd0);
      end else begin
        len = $urandom_range(0, int'(FnUnknownMax));
        if (len == int'(rpn_pkg::FN_CLEAR) && $urandom_range(0, 3) != 0)
          len = int'(rpn_pkg::FN_SHOW);
        send_token(4'(len), $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
